// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/pcxrle_pkg.sv =====
// Types and constants of the PCX run-length line decoder.
// Used by pcxrle_addr_unit and pcx_rle_line_decoder; depends on nothing.
package pcxrle_pkg;

    localparam int CODE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int COL_W    = 16;
    localparam int PLANE_W  = 2;
    localparam int OFFSET_W = 18;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 16;
    localparam int OUT_DW   = 32;

    localparam logic [CODE_W-1:0]  MARKER_MIN     = 8'hC0;
    localparam logic [COUNT_W-1:0] COUNT_ONE      = 6'd1;
    localparam logic [PLANE_W-1:0] LAST_PLANE     = 2'd2;
    localparam logic [COL_W-1:0]   BPL_RESET      = 16'd640;

    localparam logic [CFG_AW-1:0] REG_BYTES_PER_LINE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_THREE_PLANES   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [COL_W-1:0]    col_inc;
        logic                at_end;
        logic                past_end;
    } t_pos_info;

endpackage

// ===== rtl/pcxrle_addr_unit.sv =====
// Shared position unit: buffer offset, column increment and plane-end compares.
// Depends on pcxrle_pkg.
module pcxrle_addr_unit (
    input  logic [pcxrle_pkg::COL_W-1:0]   i_column,
    input  logic [pcxrle_pkg::PLANE_W-1:0] i_plane,
    input  logic                           i_three_planes,
    input  logic [pcxrle_pkg::COL_W-1:0]   i_limit,
    output pcxrle_pkg::t_pos_info          o_pos
);
    import pcxrle_pkg::*;

    logic [COL_W:0]      col_plus1;
    logic [OFFSET_W-1:0] col_x3;

    assign col_plus1 = {1'b0, i_column} + {{COL_W{1'b0}}, 1'b1};
    assign col_x3    = {2'b00, i_column} + {1'b0, i_column, 1'b0};

    always_comb begin
        o_pos.offset   = i_three_planes
                         ? col_x3 + {{(OFFSET_W-PLANE_W){1'b0}}, i_plane}
                         : {2'b00, i_column};
        o_pos.col_inc  = col_plus1[COL_W-1:0];
        o_pos.at_end   = col_plus1 >= {1'b0, i_limit};
        o_pos.past_end = i_column >= i_limit;
    end

endmodule

// ===== rtl/pcx_rle_line_decoder.sv =====
// Top level of the PCX run-length scan line decoder: sequencer and output register.
// Depends on pcxrle_pkg and pcxrle_addr_unit.
//
// Usage:
//   Input stream (i_s_*): one compressed byte per transfer in tdata[7:0].
//   Output stream (o_m_*): one decoded byte per transfer; tdata holds the
//   pixel value and its line buffer offset, tlast flags the final result of
//   an input byte, tuser flags the result that completes the scan line.
//   Config port: write i_cfg_wdata to register i_cfg_addr while i_cfg_we.
//   Index 0 is bytes per line, index 1 selects three-plane mode.
// Decode steps:
//   A literal byte is accepted, then takes one emit step; a run value byte
//   takes one emit step per emitted pixel after it is accepted; a marker
//   byte and a zero count are only accepted. The emit loop issues one result
//   per cycle, unless the output stalls, through the shared position unit;
//   s_tready is low until the byte's last result is in the output register.
// Reset: synchronous, active low; clears the decode position, the run state
//   and the output valid flag, and restores 640 bytes per line, one plane.
// Stall: a stalled output holds its result; the emit loop waits for it.
module pcx_rle_line_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcxrle_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [pcxrle_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [pcxrle_pkg::CODE_W-1:0]     i_s_tdata,   // [7:0] code_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [pcxrle_pkg::OUT_DW-1:0]     o_m_tdata,   // [7:0] pixel_value,
                                                           // [25:8] buffer_offset
    output logic                              o_m_tlast,   // last_of_run
    output logic                              o_m_tuser    // [0] line_done
);
    import pcxrle_pkg::*;

    t_state               r_state, n_state;
    logic                 r_await, n_await;
    logic [COUNT_W-1:0]   r_pending, n_pending;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [CODE_W-1:0]    r_value, n_value;
    logic [COL_W-1:0]     r_column, n_column;
    logic [PLANE_W-1:0]   r_plane, n_plane;
    logic [COL_W-1:0]     r_bpl;
    logic                 r_three;
    logic                 r_out_valid, n_out_valid;
    logic [CODE_W-1:0]    r_out_value, n_out_value;
    logic [OFFSET_W-1:0]  r_out_offset, n_out_offset;
    logic                 r_out_last, n_out_last;
    logic                 r_out_done, n_out_done;

    logic [COL_W-1:0]     limit;
    t_pos_info            pos;
    logic                 last_plane;
    logic [PLANE_W-1:0]   next_plane;
    logic [COUNT_W-1:0]   in_count;
    logic                 is_last;

    assign limit      = (r_bpl == '0) ? {{(COL_W-1){1'b0}}, 1'b1} : r_bpl;
    assign last_plane = !r_three || (r_plane >= LAST_PLANE);
    assign next_plane = last_plane ? '0 : r_plane + {{(PLANE_W-1){1'b0}}, 1'b1};

    pcxrle_addr_unit u_addr (
        .i_column       (r_column),
        .i_plane        (r_plane),
        .i_three_planes (r_three),
        .i_limit        (limit),
        .o_pos          (pos)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DW-OFFSET_W-CODE_W){1'b0}}, r_out_offset, r_out_value};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    always_comb begin
        n_state      = r_state;
        n_await      = r_await;
        n_pending    = r_pending;
        n_count      = r_count;
        n_value      = r_value;
        n_column     = r_column;
        n_plane      = r_plane;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_value  = r_out_value;
        n_out_offset = r_out_offset;
        n_out_last   = r_out_last;
        n_out_done   = r_out_done;
        in_count     = '0;
        is_last      = (r_count == COUNT_ONE) || pos.at_end;

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (r_await) begin
                        n_await   = 1'b0;
                        n_pending = '0;
                        in_count  = r_pending;
                    end else if (i_s_tdata >= MARKER_MIN) begin
                        n_pending = i_s_tdata[COUNT_W-1:0];
                        n_await   = 1'b1;
                    end else begin
                        in_count = COUNT_ONE;
                    end
                    if (in_count != '0) begin
                        n_count = in_count;
                        n_value = i_s_tdata;
                        n_state = ST_EMIT;
                        if (pos.past_end) begin
                            n_column = '0;
                            n_plane  = next_plane;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_value;
                    n_out_offset = pos.offset;
                    n_out_last   = is_last;
                    n_out_done   = pos.at_end && last_plane;
                    n_count      = r_count - COUNT_ONE;
                    if (pos.at_end) begin
                        n_column = '0;
                        n_plane  = next_plane;
                    end else begin
                        n_column = pos.col_inc;
                    end
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_await     <= 1'b0;
            r_pending   <= '0;
            r_count     <= '0;
            r_column    <= '0;
            r_plane     <= '0;
            r_bpl       <= BPL_RESET;
            r_three     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_await     <= n_await;
            r_pending   <= n_pending;
            r_count     <= n_count;
            r_column    <= n_column;
            r_plane     <= n_plane;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BYTES_PER_LINE: r_bpl   <= i_cfg_wdata;
                    REG_THREE_PLANES:   r_three <= i_cfg_wdata[0];
                    default: begin
                        r_three <= r_three;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value      <= n_value;
        r_out_value  <= n_out_value;
        r_out_offset <= n_out_offset;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

endmodule

// ===== rtl/pcxrle_checker.sv =====
// Port-level checker for pcx_rle_line_decoder, attached by bind.
// Depends on pcxrle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcxrle_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [pcxrle_pkg::OUT_DW-1:0] o_m_tdata,
    input logic                          o_m_tlast,
    input logic                          o_m_tuser
);
    import pcxrle_pkg::*;

    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
    `ASSERT_CLK(a_done_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser |-> o_m_tlast)
    `ASSERT_CLK(a_busy_mid_run, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast |-> !o_s_tready)
    `ASSERT_NEVER(a_pad_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[OUT_DW-1:OFFSET_W+CODE_W] != '0))

endmodule

bind pcx_rle_line_decoder pcxrle_checker u_pcxrle_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for pcx_rle_line_decoder: run-length decode of scan line bytes.
// Predicts each pixel transfer from its own decode state; depends on pcxrle_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import pcxrle_pkg::*;

    typedef struct {
        logic [7:0]          pixel;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic                done;
    } pixel_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_addr;
    logic [CFG_DW-1:0]   i_cfg_wdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [CODE_W-1:0]   i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_DW-1:0]   o_m_tdata;
    logic                o_m_tlast;
    logic                o_m_tuser;

    pixel_result_t pixel_q[$];
    int            error_count = 0;
    bit            no_gaps = 1'b0;

    // decoder shadow state
    logic [15:0] line_len;
    bit          color_mode;
    bit          want_run_value;
    int unsigned run_count;
    int unsigned column;
    int unsigned plane;

    pcx_rle_line_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic bit advance_plane();
        bit line_end;
        if (!color_mode || plane >= LAST_PLANE) begin
            plane = 0;
            line_end = 1'b1;
        end else begin
            plane = plane + 1;
            line_end = 1'b0;
        end
        column = 0;
        return line_end;
    endfunction

    task automatic decode_byte(input logic [7:0] code);
        int unsigned   count;
        int unsigned   limit;
        logic [7:0]    value;
        pixel_result_t res;
        if (want_run_value) begin
            want_run_value = 1'b0;
            count = run_count;
            run_count = 0;
            value = code;
        end else if (code >= MARKER_MIN) begin
            run_count = code[5:0];
            want_run_value = 1'b1;
            return;
        end else begin
            count = 1;
            value = code;
        end
        if (count == 0)
            return;
        limit = (line_len == 16'd0) ? 1 : line_len;
        if (column >= limit)
            void'(advance_plane());
        while (count != 0 && column < limit) begin
            res.pixel = value;
            res.offset = color_mode ? OFFSET_W'(plane + 3 * column) : OFFSET_W'(column);
            column = column + 1;
            count = count - 1;
            res.last = (count == 0) || (column >= limit);
            res.done = 1'b0;
            if (column >= limit) begin
                res.done = advance_plane();
                pixel_q.push_back(res);
                break;
            end
            pixel_q.push_back(res);
        end
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_code(input logic [7:0] code);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(code);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == REG_BYTES_PER_LINE)
            line_len = data;
        else
            color_mode = data[0];
    endtask

    task automatic configure(input logic [15:0] len, input bit colors);
        drain();
        write_reg(REG_BYTES_PER_LINE, len);
        write_reg(REG_THREE_PLANES, {15'd0, colors});
    endtask

    task automatic test_literals();
        send_code(8'h00);
        send_code(8'hBF);
        send_code(8'h55);
        send_code(8'hAA);
    endtask

    task automatic test_runs();
        configure(16'd4, 1'b0);
        send_code(8'hC0);
        send_code(8'h12);
        send_code(8'hC1);
        send_code(8'hC0);
        send_code(8'hC3);
        send_code(8'hFF);
        send_code(8'hFF);
        send_code(8'h00);
        send_code(8'h3C);
    endtask

    task automatic test_three_planes();
        configure(16'd2, 1'b1);
        send_code(8'hC7);
        send_code(8'h33);
        send_code(8'h01);
        send_code(8'h02);
    endtask

    task automatic test_short_lines();
        configure(16'd0, 1'b0);
        send_code(8'h11);
        send_code(8'hC2);
        send_code(8'h22);
        configure(16'd1, 1'b1);
        send_code(8'hC4);
        send_code(8'h44);
    endtask

    task automatic test_midline_changes();
        configure(16'd10, 1'b1);
        repeat (5) send_code(8'h66);
        configure(16'd3, 1'b1);
        send_code(8'h77);
        send_code(8'h78);
        configure(16'd3, 1'b0);
        send_code(8'hC5);
        send_code(8'h79);
    endtask

    task automatic test_longest_line();
        configure(16'hFFFF, 1'b0);
        send_code(8'hFF);
        send_code(8'h7E);
        send_code(8'h81);
    endtask

    task automatic test_random_stream();
        logic [15:0] len;
        int          pick;
        for (int phase = 0; phase < 10; phase++) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len = 16'd0;
                1:       len = 16'd1;
                2:       len = 16'hFFFF;
                3:       len = 16'($urandom_range(17, 65534));
                default: len = 16'($urandom_range(2, 16));
            endcase
            configure(len, $urandom_range(0, 1));
            no_gaps = (phase % 3 == 1);
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    if ($urandom_range(0, 5) == 0)
                        send_code(MARKER_MIN | 8'($urandom_range(0, 63)));
                    else
                        send_code(MARKER_MIN | 8'($urandom_range(0, 8)));
                    send_code(8'($urandom_range(0, 255)));
                    n++;
                end else if (pick < 5) begin
                    send_code(8'($urandom_range(0, 255)));
                end else begin
                    send_code(8'($urandom_range(0, 8'hBF)));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        pixel_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                report("unexpected transfer", o_m_tdata, 0);
            end else begin
                want = pixel_q.pop_front();
                if (o_m_tdata[7:0] !== want.pixel)
                    report("pixel_value", o_m_tdata[7:0], want.pixel);
                if (o_m_tdata[25:8] !== want.offset)
                    report("buffer_offset", o_m_tdata[25:8], want.offset);
                if (o_m_tlast !== want.last)
                    report("last_of_run", o_m_tlast, want.last);
                if (o_m_tuser !== want.done)
                    report("line_done", o_m_tuser, want.done);
            end
        end
    end

    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_BYTES_PER_LINE;
        i_cfg_wdata = 16'd0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 8'd0;
        line_len       = BPL_RESET;
        color_mode     = 1'b0;
        want_run_value = 1'b0;
        run_count      = 0;
        column         = 0;
        plane          = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_literals();
        test_runs();
        test_three_planes();
        test_short_lines();
        test_midline_changes();
        test_longest_line();
        test_random_stream();
        drain();
        repeat (10) @(negedge i_clk);

        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
